// File: sv/ghh_pkg.sv
// Shared types and constants for the gyro heading-hold drive block.
`timescale 1ns / 1ps

package ghh_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_ERR,
        S_PROD,
        S_RECIP,
        S_CORR,
        S_OUT
    } ghh_state_t;

    typedef enum logic [1:0] {
        REG_TARGET_HEADING = 2'd0,
        REG_RATE_DEADBAND  = 2'd1,
        REG_GAIN_Q4        = 2'd2,
        REG_MAX_CORRECTION = 2'd3
    } ghh_reg_idx_t;

    // Step enables from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic mul;
        logic acc;
        logic err;
        logic prod;
        logic recip;
        logic corr;
        logic load_out;
    } ghh_cmd_t;

    localparam int IN_BITS  = 41;
    localparam int OUT_BITS = 18;

    localparam logic signed [31:0] TARGET_RESET   = 32'sd0;
    localparam logic [14:0]        DEADBAND_RESET = 15'd50;
    localparam logic [11:0]        GAIN_RESET     = 12'd160;
    localparam logic [7:0]         MAXCORR_RESET  = 8'd30;

    // Scale 0.01 deg to 1e-8 deg
    localparam logic signed [20:0] TARGET_SCALE = 21'sd1000000;
    localparam logic signed [54:0] HEAD_LIM     = 55'sd4503599627370496;  // 2^52
    localparam logic signed [54:0] ERR_LIM      = 55'sd1099511627776;     // 2^40

    // error*gain / 1.6e9 == (error*gain >> 12) / 390625
    localparam logic [52:0] PROD_SAT     = 53'd409600000000;  // 256 * 1.6e9
    localparam logic [18:0] DIV_D        = 19'd390625;
    localparam logic [16:0] DIV_RECIP    = 17'd87960;         // floor(2^35 / 390625)

endpackage

// File: sv/ghh_ctrl.sv
// Sequencing controller for the heading-hold drive: handshakes and step enables.
`timescale 1ns / 1ps

module ghh_ctrl
    import ghh_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_axis_tvalid,
    output logic     s_axis_tready,
    output logic     m_axis_tvalid,
    input  logic     m_axis_tready,
    output ghh_cmd_t cmd
);

    ghh_state_t state_reg;
    ghh_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                    state_next = S_MUL;
            end
            S_MUL:   state_next = S_ACC;
            S_ACC:   state_next = S_ERR;
            S_ERR:   state_next = S_PROD;
            S_PROD:  state_next = S_RECIP;
            S_RECIP: state_next = S_CORR;
            S_CORR:  state_next = S_OUT;
            S_OUT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        s_axis_tready  = 1'b0;
        out_valid_next = out_valid_reg && !m_axis_tready;
        case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                cmd.capture   = s_axis_tvalid;
            end
            S_MUL:   cmd.mul   = 1'b1;
            S_ACC:   cmd.acc   = 1'b1;
            S_ERR:   cmd.err   = 1'b1;
            S_PROD:  cmd.prod  = 1'b1;
            S_RECIP: cmd.recip = 1'b1;
            S_CORR:  cmd.corr  = 1'b1;
            S_OUT:
            begin
                cmd.load_out = out_free;
                if (out_free)
                    out_valid_next = 1'b1;
            end
            default: cmd = '0;
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> state_reg == S_MUL)
        else $error("accepted beat did not start the sequence");

    a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath step enabled");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> m_axis_tvalid)
        else $error("loaded result not presented");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !m_axis_tvalid || m_axis_tready)
        else $error("result register overwritten while held");
`endif

endmodule

// File: sv/ghh_datapath.sv
// Datapath: config registers, heading accumulator, correction and wheel mapping.
`timescale 1ns / 1ps

module ghh_datapath
    import ghh_pkg::*;
#(
    parameter int PWM_MAX = 255
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  ghh_cmd_t            cmd,
    input  logic [IN_BITS-1:0]  in_data,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    output logic [OUT_BITS-1:0] out_data
);

    localparam int DutyCapInt = (PWM_MAX < 255) ? PWM_MAX : 255;
    localparam logic [9:0] DUTY_CAP = 10'(DutyCapInt);

    // configuration
    logic signed [31:0] target_reg;
    logic [14:0]        deadband_reg;
    logic [11:0]        gain_reg;
    logic [7:0]         maxcorr_reg;

    // state
    logic signed [63:0] accum_reg;
    logic signed [63:0] accum_next;

    // per-item working registers
    logic signed [15:0] rate_reg;
    logic [15:0]        us_reg;
    logic signed [8:0]  base_reg;
    logic signed [32:0] delta_reg;
    logic               apply_reg;
    logic signed [52:0] tgt_reg;
    logic [40:0]        emag_reg;
    logic               eneg_reg;
    logic [52:0]        prod_reg;
    logic [26:0]        quot_x_reg;
    logic [7:0]         q0_reg;
    logic               qsat_reg;
    logic [7:0]         cmag_reg;
    logic [OUT_BITS-1:0] out_reg;

    // next values
    logic signed [32:0] delta_next;
    logic signed [52:0] tgt_next;
    logic [16:0]        arate;
    logic               apply_next;
    logic signed [64:0] diff;
    logic signed [54:0] h_clamp;
    logic signed [54:0] err_full;
    logic signed [54:0] err_clamp;
    logic [40:0]        emag_next;
    logic [52:0]        prod_next;
    logic [43:0]        recip_prod;
    logic [26:0]        qd;
    logic [26:0]        rem;
    logic [8:0]         qfix;
    logic [7:0]         qsel;
    logic [7:0]         cmag_next;
    logic signed [9:0]  corr;
    logic signed [10:0] right_cmd;
    logic signed [10:0] left_cmd;
    logic [9:0]         right_mag;
    logic [9:0]         left_mag;
    logic [7:0]         right_duty;
    logic [7:0]         left_duty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg   <= TARGET_RESET;
            deadband_reg <= DEADBAND_RESET;
            gain_reg     <= GAIN_RESET;
            maxcorr_reg  <= MAXCORR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TARGET_HEADING: target_reg   <= $signed(cfg_data);
                REG_RATE_DEADBAND:  deadband_reg <= cfg_data[14:0];
                REG_GAIN_Q4:        gain_reg     <= cfg_data[11:0];
                REG_MAX_CORRECTION: maxcorr_reg  <= cfg_data[7:0];
                default:            target_reg   <= target_reg;
            endcase
        end
    end

    // step 1: rate*time and the scaled target
    assign arate      = rate_reg[15] ? 17'(-{rate_reg[15], rate_reg}) : {1'b0, rate_reg};
    assign apply_next = arate > {2'b00, deadband_reg};
    assign delta_next = rate_reg * $signed({1'b0, us_reg});
    assign tgt_next   = target_reg * TARGET_SCALE;

    // step 2: saturating accumulate
    assign diff = {accum_reg[63], accum_reg} - 65'(delta_reg);
    always_comb
    begin
        accum_next = accum_reg;
        if (apply_reg)
        begin
            if (diff[64] != diff[63])
                accum_next = diff[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            else
                accum_next = diff[63:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            accum_reg <= '0;
        else if (cmd.acc)
            accum_reg <= accum_next;
    end

    // step 3: heading error, clamped
    always_comb
    begin
        if (accum_reg > 64'(HEAD_LIM))
            h_clamp = HEAD_LIM;
        else if (accum_reg < -64'(HEAD_LIM))
            h_clamp = -HEAD_LIM;
        else
            h_clamp = accum_reg[54:0];
        err_full = 55'(tgt_reg) - h_clamp;
        if (err_full > ERR_LIM)
            err_clamp = ERR_LIM;
        else if (err_full < -ERR_LIM)
            err_clamp = -ERR_LIM;
        else
            err_clamp = err_full;
        emag_next = err_clamp[54] ? 41'(-err_clamp) : err_clamp[40:0];
    end

    // step 4/5/6: gain, reciprocal quotient, correction
    assign prod_next  = emag_reg * gain_reg;
    assign recip_prod = prod_reg[38:12] * DIV_RECIP;
    assign qd         = q0_reg * DIV_D;
    assign rem        = quot_x_reg - qd;

    always_comb
    begin
        qfix = {1'b0, q0_reg} + 9'(rem >= 27'(DIV_D));
        qsel = (qsat_reg || qfix[8]) ? 8'hFF : qfix[7:0];
        cmag_next = (qsel > maxcorr_reg) ? maxcorr_reg : qsel;
    end

    // step 7: wheel commands
    assign corr      = eneg_reg ? -$signed({2'b00, cmag_reg}) : $signed({2'b00, cmag_reg});
    assign right_cmd = 11'(base_reg) - 11'(corr);
    assign left_cmd  = -(11'(base_reg) + 11'(corr));
    assign right_mag = right_cmd[10] ? 10'(-right_cmd) : right_cmd[9:0];
    assign left_mag  = left_cmd[10] ? 10'(-left_cmd) : left_cmd[9:0];
    assign right_duty = 8'((right_mag > DUTY_CAP) ? DUTY_CAP : right_mag);
    assign left_duty  = 8'((left_mag > DUTY_CAP) ? DUTY_CAP : left_mag);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            rate_reg <= $signed(in_data[15:0]);
            us_reg   <= in_data[31:16];
            base_reg <= $signed(in_data[40:32]);
        end
        if (cmd.mul)
        begin
            delta_reg <= delta_next;
            apply_reg <= apply_next;
            tgt_reg   <= tgt_next;
        end
        if (cmd.err)
        begin
            emag_reg <= emag_next;
            eneg_reg <= err_clamp[54];
        end
        if (cmd.prod)
            prod_reg <= prod_next;
        if (cmd.recip)
        begin
            qsat_reg   <= prod_reg >= PROD_SAT;
            quot_x_reg <= prod_reg[38:12];
            q0_reg     <= recip_prod[42:35];
        end
        if (cmd.corr)
            cmag_reg <= cmag_next;
        if (cmd.load_out)
            out_reg <= {left_duty, !left_cmd[10] && (left_cmd != '0),
                        right_duty, !right_cmd[10] && (right_cmd != '0)};
    end

    assign out_data = out_reg;

endmodule

// File: sv/gyro_heading_hold_drive_top.sv
// Top level of the gyro heading-hold differential drive block.
`timescale 1ns / 1ps

// Heading hold for a two-wheel drive: each input beat is one gyro sample; the
// yaw rate times the elapsed time is taken off a saturating 64-bit heading
// (1e-8 deg), the error to the target heading is scaled by gain_q4/16 per
// degree, clamped to +/- max_correction, and mapped to a direction flag and an
// 8-bit duty per wheel. One result beat per input beat, in order. From acceptance
// to a loaded result the controller steps one multiply or wide add per cycle
// (rate*time, accumulate, error, gain, reciprocal quotient, correction, wheel
// mapping); the load waits while the previous result is still held unaccepted.
// The next beat is taken in the cycle after the load, so a new item is not taken
// before the last one is loaded, but it is taken even while the previous result
// is still held at the output.
// Config writes are always accepted and must be done while the block is idle.
module gyro_heading_hold_drive_top
    import ghh_pkg::*;
#(
    parameter int PWM_MAX = 255
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] yaw_rate, [31:16] elapsed_us, [40:32] base_speed, [47:41] zero
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] right_forward, [8:1] right_duty, [9] left_forward, [17:10] left_duty,
    // [23:18] zero
    output logic [23:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    ghh_cmd_t            cmd;
    logic [OUT_BITS-1:0] out_data;

    assign cfg_ready = 1'b1;

    ghh_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cmd           (cmd)
    );

    ghh_datapath #(
        .PWM_MAX (PWM_MAX)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (s_axis_tdata[IN_BITS-1:0]),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_data  (out_data)
    );

    assign m_axis_tdata = {6'd0, out_data};

endmodule
